// ===== sv/tibd_pkg.sv =====
// Package for the timed integrating button debouncer.
// Register indexes, reset values and the result word type; no dependencies.
package tibd_pkg;

    localparam int unsigned INTEG_W   = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL  = 2'd1;

    localparam logic [INTEG_W-1:0] HOLD_THRESHOLD_RST = 16'd50;
    localparam logic               PRESSED_LEVEL_RST  = 1'b0;

    typedef struct packed {
        logic [INTEG_W-1:0] hold_threshold;
        logic               pressed_level;
    } tibd_cfg_t;

    typedef struct packed {
        logic               debounced;
        logic               turned_on;
        logic               turned_off;
        logic [INTEG_W-1:0] integrator_level;
    } tibd_res_t;

endpackage

// ===== sv/tibd_cfg_regs.sv =====
// Configuration register file of the debouncer.
// Depends on tibd_pkg.
module tibd_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tibd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tibd_pkg::CFG_DAT_W-1:0]   cfg_data,
    output tibd_pkg::tibd_cfg_t              cfg
);

    tibd_pkg::tibd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_threshold <= tibd_pkg::HOLD_THRESHOLD_RST;
            cfg_reg.pressed_level  <= tibd_pkg::PRESSED_LEVEL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                tibd_pkg::REG_HOLD_THRESHOLD: cfg_reg.hold_threshold <= cfg_data;
                tibd_pkg::REG_PRESSED_LEVEL:  cfg_reg.pressed_level  <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/tibd_core.sv =====
// Integrator state and its single-pass update for one sample word.
// Depends on tibd_pkg.
module tibd_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            raw_level,
    input  logic [tibd_pkg::TIME_W-1:0]     now_ms,
    input  tibd_pkg::tibd_cfg_t             cfg,
    output tibd_pkg::tibd_res_t             res
);

    localparam int unsigned W = tibd_pkg::INTEG_W;

    // only the low bits of the timestamp take part in the elapsed time
    logic [W-1:0] integ_reg, integ_next;
    logic [W-1:0] last_reg, last_next;
    logic         state_reg, state_next;

    logic         pressed;
    logic [W-1:0] elapsed;
    logic [W:0]   sum;
    logic [W:0]   dec;
    logic [W-1:0] upd;

    always_comb begin
        pressed    = (raw_level == cfg.pressed_level);
        elapsed    = now_ms[W-1:0] - last_reg;
        sum        = {1'b0, integ_reg} + {1'b0, elapsed};
        dec        = {1'b0, elapsed} + {{W{1'b0}}, 1'b1};
        integ_next = integ_reg;
        last_next  = last_reg;
        state_next = state_reg;
        upd        = integ_reg;

        if (pressed) begin
            upd = (sum > {1'b0, cfg.hold_threshold}) ? cfg.hold_threshold : sum[W-1:0];
        end else begin
            upd = (dec > {1'b0, integ_reg}) ? '0 : (integ_reg - dec[W-1:0]);
        end

        if (pressed && integ_reg == '0) begin
            integ_next = {{(W-1){1'b0}}, 1'b1};
            last_next  = now_ms[W-1:0];
        end else if (integ_reg != '0 && elapsed != '0) begin
            integ_next = upd;
            last_next  = now_ms[W-1:0];
            if (upd == cfg.hold_threshold) state_next = 1'b1;
            if (upd == '0)                 state_next = 1'b0;
        end

        res.debounced        = state_next;
        res.turned_on        = state_next & ~state_reg;
        res.turned_off       = state_reg & ~state_next;
        res.integrator_level = integ_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            last_reg  <= '0;
            state_reg <= 1'b0;
        end else if (advance) begin
            integ_reg <= integ_next;
            last_reg  <= last_next;
            state_reg <= state_next;
        end
    end

    a_pressed_needs_charge: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg |-> integ_reg != '0)
        else $error("debounced set with empty integrator");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(integ_reg) && $stable(state_reg) && $stable(last_reg))
        else $error("state moved without a word");

    a_on_at_threshold: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.turned_on |-> integ_next == cfg.hold_threshold && integ_reg != '0)
        else $error("switch-on away from threshold");

endmodule

// ===== sv/timed_integrating_button_debouncer_unit.sv =====
// Pipeline: a sample is taken into the input register, its result into the result register.
// Throughput: one sample word per cycle unless m_ready stalls the result register;
// the 17-bit add or subtract and compare sit between the input and result registers.
// Reset: synchronous active-low aresetn clears integrator, timestamp, debounced state,
// both stage valids, and loads hold_threshold = 50, pressed_level = 0.
module timed_integrating_button_debouncer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_raw_level,
    input  logic [tibd_pkg::TIME_W-1:0]      s_now_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_debounced,
    output logic                             m_turned_on,
    output logic                             m_turned_off,
    output logic [tibd_pkg::INTEG_W-1:0]     m_integrator_level,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tibd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tibd_pkg::CFG_DAT_W-1:0]   cfg_data
);

    tibd_pkg::tibd_cfg_t cfg;
    tibd_pkg::tibd_res_t res;
    tibd_pkg::tibd_res_t out_reg;

    logic                          in_valid_reg;
    logic                          raw_reg;
    logic [tibd_pkg::TIME_W-1:0]   now_reg;
    logic                          out_valid_reg;
    logic                          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tibd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tibd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .raw_level (raw_reg),
        .now_ms    (now_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_level;
            now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_debounced        = out_reg.debounced;
    assign m_turned_on        = out_reg.turned_on;
    assign m_turned_off       = out_reg.turned_off;
    assign m_integrator_level = out_reg.integrator_level;

    a_edges_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.turned_on && out_reg.turned_off))
        else $error("both edge pulses in one word");

    a_on_edge_level: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.turned_on |-> out_reg.debounced)
        else $error("switch-on pulse with released level");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && out_valid_reg)
        else $error("word lost under stall");

endmodule

// ===== dv/tb.sv =====
// Testbench for timed_integrating_button_debouncer_unit: directed and random sample words,
// random idling on both channels, results checked against a cycle-free debouncer mirror.
// Depends on tibd_pkg and the unit itself.
module tb;

    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct packed {
        logic                        raw;
        logic [tibd_pkg::TIME_W-1:0] stamp;
    } sample_word_t;

    logic                             aclk               = 1'b0;
    logic                             aresetn            = 1'b0;
    logic                             s_valid            = 1'b0;
    logic                             s_ready;
    logic                             s_raw_level        = 1'b0;
    logic [tibd_pkg::TIME_W-1:0]      s_now_ms           = '0;
    logic                             m_valid;
    logic                             m_ready            = 1'b0;
    logic                             m_debounced;
    logic                             m_turned_on;
    logic                             m_turned_off;
    logic [tibd_pkg::INTEG_W-1:0]     m_integrator_level;
    logic                             cfg_valid          = 1'b0;
    logic                             cfg_ready;
    logic [tibd_pkg::CFG_IDX_W-1:0]   cfg_index          = '0;
    logic [tibd_pkg::CFG_DAT_W-1:0]   cfg_data           = '0;

    sample_word_t        pending_samples[$];
    tibd_pkg::tibd_res_t expected_results[$];

    int unsigned errors   = 0;
    int unsigned cycles   = 0;
    int unsigned queued   = 0;
    int unsigned src_gap  = 0;
    int unsigned sink_gap = 0;
    bit          steady   = 1'b0;
    bit          s_fire   = 1'b0;
    bit          m_fire   = 1'b0;

    // debouncer mirror
    logic [tibd_pkg::INTEG_W-1:0] thr_m     = tibd_pkg::HOLD_THRESHOLD_RST;
    logic                         plvl_m    = tibd_pkg::PRESSED_LEVEL_RST;
    logic [tibd_pkg::INTEG_W-1:0] integ_m   = '0;
    logic [tibd_pkg::TIME_W-1:0]  last_ms_m = '0;
    logic                         deb_m     = 1'b0;
    logic [tibd_pkg::TIME_W-1:0]  t_now     = '0;

    timed_integrating_button_debouncer_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_raw_level        (s_raw_level),
        .s_now_ms           (s_now_ms),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_debounced        (m_debounced),
        .m_turned_on        (m_turned_on),
        .m_turned_off       (m_turned_off),
        .m_integrator_level (m_integrator_level),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic tibd_pkg::tibd_res_t debounce_step(logic raw,
                                                          logic [tibd_pkg::TIME_W-1:0] stamp);
        tibd_pkg::tibd_res_t          r;
        logic                         was;
        logic [tibd_pkg::INTEG_W-1:0] elapsed;
        logic [tibd_pkg::INTEG_W:0]   sum;
        logic [tibd_pkg::INTEG_W:0]   dec;
        was = deb_m;
        if (raw == plvl_m && integ_m == '0) begin
            integ_m   = tibd_pkg::INTEG_W'(1);
            last_ms_m = stamp;
        end else if (integ_m != '0) begin
            elapsed = stamp[tibd_pkg::INTEG_W-1:0] - last_ms_m[tibd_pkg::INTEG_W-1:0];
            if (elapsed != '0) begin
                last_ms_m = stamp;
                if (raw == plvl_m) begin
                    sum     = {1'b0, integ_m} + {1'b0, elapsed};
                    integ_m = (sum > {1'b0, thr_m}) ? thr_m : sum[tibd_pkg::INTEG_W-1:0];
                end else begin
                    dec     = {1'b0, elapsed} + 1'b1;
                    integ_m = (dec > {1'b0, integ_m}) ? '0
                                                      : integ_m - dec[tibd_pkg::INTEG_W-1:0];
                end
                if (integ_m == thr_m) deb_m = 1'b1;
                if (integ_m == '0) deb_m = 1'b0;
            end
        end
        r.debounced        = deb_m;
        r.turned_on        = deb_m & ~was;
        r.turned_off       = was & ~deb_m;
        r.integrator_level = integ_m;
        return r;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= 40)
            $display("mismatch %0s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
    endtask

    task automatic push_word(logic raw, logic [tibd_pkg::TIME_W-1:0] stamp);
        sample_word_t w;
        w.raw   = raw;
        w.stamp = stamp;
        t_now   = stamp;
        pending_samples.push_back(w);
        queued++;
    endtask

    task automatic push_step(logic raw, logic [tibd_pkg::TIME_W-1:0] delta);
        push_word(raw, t_now + delta);
    endtask

    task automatic write_reg(logic [tibd_pkg::CFG_IDX_W-1:0] idx,
                             logic [tibd_pkg::CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx == tibd_pkg::REG_HOLD_THRESHOLD) thr_m = data;
        else if (idx == tibd_pkg::REG_PRESSED_LEVEL) plvl_m = data[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(int unsigned n_words);
        int unsigned stop_at;
        int unsigned dmax;
        int unsigned k;
        int unsigned kind;
        stop_at = queued + n_words;
        dmax    = thr_m / 4 + 1;
        while (queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // press run then release run, the odd contact bounce inside each
                k = $urandom_range(1, 12);
                repeat (k)
                    push_step(($urandom_range(0, 7) == 0) ? ~plvl_m : plvl_m,
                              $urandom_range(0, dmax));
                k = $urandom_range(1, 12);
                repeat (k)
                    push_step(($urandom_range(0, 7) == 0) ? plvl_m : ~plvl_m,
                              $urandom_range(0, dmax));
            end else if (kind <= 7) begin
                k = $urandom_range(2, 8);
                repeat (k) push_step(1'($urandom_range(0, 1)), $urandom_range(0, 3));
            end else if (kind == 8) begin
                push_word(1'($urandom_range(0, 1)), $urandom);
            end else begin
                push_step(1'($urandom_range(0, 1)), $urandom);
            end
        end
    endtask

    always @(negedge aclk) begin : source
        sample_word_t next_word;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (src_gap != 0) begin
                s_valid <= 1'b0;
                src_gap--;
            end else if (pending_samples.size() != 0) begin
                next_word = pending_samples.pop_front();
                s_valid     <= 1'b1;
                s_raw_level <= next_word.raw;
                s_now_ms    <= next_word.stamp;
                src_gap = steady ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : sink
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_fire) sink_gap = steady ? 0 : $urandom_range(0, 4);
            if (sink_gap != 0) begin
                m_ready <= 1'b0;
                sink_gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        tibd_pkg::tibd_res_t want;
        s_fire <= s_valid && s_ready;
        m_fire <= m_valid && m_ready;
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("timed_integrating_button_debouncer_unit verification failed");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(debounce_step(s_raw_level, s_now_ms));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report("result word with none expected", m_integrator_level, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_debounced !== want.debounced)
                        report("debounced", m_debounced, want.debounced);
                    if (m_turned_on !== want.turned_on)
                        report("turned_on", m_turned_on, want.turned_on);
                    if (m_turned_off !== want.turned_off)
                        report("turned_off", m_turned_off, want.turned_off);
                    if (m_integrator_level !== want.integrator_level)
                        report("integrator_level", m_integrator_level, want.integrator_level);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned p;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: threshold 50, pressed when low
        push_word(1'b1, 32'h0000_0000);     // idle, released: ignored
        push_word(1'b0, 32'h0000_0064);     // arm
        push_word(1'b0, 32'h0000_0064);     // no time passed
        push_word(1'b0, 32'h0000_0078);
        push_word(1'b1, 32'h0000_007D);
        push_word(1'b0, 32'h0001_007D);     // elapsed zero modulo 2^16
        push_word(1'b0, 32'hFFFF_FFFF);     // large elapsed, saturates
        push_word(1'b0, 32'h0000_0004);     // timestamp wrap
        push_word(1'b1, 32'h0000_0003);     // elapsed 0xFFFF, floors at zero
        push_word(1'b1, 32'h8000_0000);
        push_word(1'b0, 32'h8000_0000);
        push_word(1'b0, 32'h8000_0031);     // lands exactly on threshold
        drain();
        write_reg(tibd_pkg::REG_HOLD_THRESHOLD, 16'd7);   // lowered while armed
        push_word(1'b0, 32'h8000_0032);
        push_word(1'b1, 32'h8000_0034);
        drain();
        write_reg(tibd_pkg::REG_HOLD_THRESHOLD, 16'd0);
        write_reg(tibd_pkg::REG_PRESSED_LEVEL, 16'hFFFF);
        push_word(1'b1, 32'h8000_0035);
        push_word(1'b1, 32'h8000_0036);
        push_word(1'b0, 32'h8000_0037);
        push_word(1'b1, 32'h8000_0038);
        push_word(1'b1, 32'h8000_0039);
        drain();
        write_reg(tibd_pkg::REG_HOLD_THRESHOLD, 16'hFFFF);
        write_reg(tibd_pkg::REG_PRESSED_LEVEL, 16'h0000);
        push_word(1'b0, 32'h0000_0000);
        push_word(1'b0, 32'h0000_FFFF);     // 17-bit sum
        push_word(1'b0, 32'h0001_FFFE);
        push_word(1'b1, 32'h0002_FFFD);
        push_word(1'b1, 32'hFFFF_FFFF);
        drain();

        t_now = $urandom;
        steady = 1'b1;
        write_reg(tibd_pkg::REG_HOLD_THRESHOLD, 16'd1);
        write_reg(tibd_pkg::REG_PRESSED_LEVEL, 16'd1);
        random_phase(110);
        drain();
        steady = 1'b0;
        write_reg(tibd_pkg::REG_HOLD_THRESHOLD, 16'hFFFF);
        write_reg(tibd_pkg::REG_PRESSED_LEVEL, {15'($urandom_range(0, 32767)), 1'b0});
        random_phase(110);
        for (p = 0; p < 7; p++) begin
            drain();
            steady = (p % 3 == 1);
            write_reg(tibd_pkg::REG_HOLD_THRESHOLD,
                      (p == 3) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(2, 90)));
            write_reg(tibd_pkg::REG_PRESSED_LEVEL,
                      {15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1))});
            random_phase(110);
        end
        drain();

        if (errors == 0)
            $display("timed_integrating_button_debouncer_unit verification clean");
        else
            $display("timed_integrating_button_debouncer_unit verification failed");
        $finish;
    end

endmodule
